/* rtl/core/bbps_pkg.sv */
// Shared types and codes for the backup block payload splitter.
// No dependencies; used by bbps_parser and the top level.
package bbps_pkg;

  localparam logic [2:0] KIND_COUNT   = 3'd0;
  localparam logic [2:0] KIND_ID      = 3'd1;
  localparam logic [2:0] KIND_LEN     = 3'd2;
  localparam logic [2:0] KIND_PAGE    = 3'd3;
  localparam logic [2:0] KIND_MAIN    = 3'd4;
  localparam logic [2:0] KIND_DISCARD = 3'd5;

  // id byte plus four length bytes
  localparam logic [31:0] HEADER_BYTES = 32'd5;

  typedef struct packed {
    logic        images_present;
    logic [31:0] payload_length;
    logic        first_byte;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic        record_ok;
    logic        record_end;
    logic        malformed;
    logic [31:0] page_length;
    logic [7:0]  block_number;
    logic [2:0]  byte_kind;
    logic [7:0]  byte_out;
  } result_t;

endpackage

/* rtl/core/bbps_parser.sv */
// Parse state and per-beat classification for the payload splitter.
// Depends on bbps_pkg; state advances on each beat taken from the input register.
module bbps_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  bbps_pkg::item_t  item,
  output bbps_pkg::result_t result
);

  localparam logic [2:0] PH_COUNT   = 3'd0;
  localparam logic [2:0] PH_ID      = 3'd1;
  localparam logic [2:0] PH_LEN     = 3'd2;
  localparam logic [2:0] PH_PAGE    = 3'd3;
  localparam logic [2:0] PH_MAIN    = 3'd4;
  localparam logic [2:0] PH_DISCARD = 3'd5;

  logic [2:0]  phase;
  logic [31:0] bytes_remaining;
  logic [7:0]  blocks_remaining;
  logic [7:0]  current_block;
  logic [31:0] length_accumulator;
  logic [1:0]  length_byte_index;
  logic [31:0] page_bytes_left;
  logic        error_seen;

  logic [2:0]  phase_next;
  logic [31:0] bytes_remaining_next;
  logic [7:0]  blocks_remaining_next;
  logic [7:0]  current_block_next;
  logic [31:0] length_accumulator_next;
  logic [1:0]  length_byte_index_next;
  logic [31:0] page_bytes_left_next;
  logic        error_seen_next;

  // state as seen by this beat (after a record start)
  logic [2:0]  e_ph;
  logic [31:0] e_rem;
  logic [7:0]  e_br;
  logic [7:0]  e_cb;
  logic [31:0] e_acc;
  logic [1:0]  e_idx;
  logic [31:0] e_pbl;
  logic        e_err;

  logic [31:0] rem_after;
  logic [31:0] acc_or;
  logic [31:0] pbl_dec;
  logic [7:0]  br_dec;
  logic        hdr_short;
  logic        do_finish;

  always_comb begin
    e_ph  = phase;
    e_rem = bytes_remaining;
    e_br  = blocks_remaining;
    e_cb  = current_block;
    e_acc = length_accumulator;
    e_idx = length_byte_index;
    e_pbl = page_bytes_left;
    e_err = error_seen;
    if (item.first_byte) begin
      e_rem = (item.payload_length != 32'd0) ? item.payload_length : 32'd1;
      e_err = 1'b0;
      e_cb  = 8'd0;
      e_br  = 8'd0;
      e_acc = 32'd0;
      e_idx = 2'd0;
      e_pbl = 32'd0;
      e_ph  = item.images_present ? PH_COUNT : PH_MAIN;
    end

    phase_next              = e_ph;
    bytes_remaining_next    = e_rem;
    blocks_remaining_next   = e_br;
    current_block_next      = e_cb;
    length_accumulator_next = e_acc;
    length_byte_index_next  = e_idx;
    page_bytes_left_next    = e_pbl;
    error_seen_next         = e_err;

    result              = '0;
    result.byte_out     = item.data_byte;
    result.byte_kind    = bbps_pkg::KIND_DISCARD;

    rem_after = e_rem - 32'd1;
    acc_or    = e_acc | (32'(item.data_byte) << {e_idx, 3'b000});
    pbl_dec   = (e_pbl != 32'd0) ? e_pbl - 32'd1 : 32'd0;
    br_dec    = (e_br != 8'd0) ? e_br - 8'd1 : 8'd0;
    hdr_short = rem_after < bbps_pkg::HEADER_BYTES;
    do_finish = 1'b0;

    if (e_rem != 32'd0) begin
      case (e_ph)
        PH_COUNT: begin
          result.byte_kind      = bbps_pkg::KIND_COUNT;
          blocks_remaining_next = item.data_byte;
          current_block_next    = 8'd0;
          if (item.data_byte == 8'd0) begin
            phase_next = PH_MAIN;
          end else if (hdr_short) begin
            result.malformed = 1'b1;
            error_seen_next  = 1'b1;
            phase_next       = PH_DISCARD;
          end else begin
            phase_next = PH_ID;
          end
        end
        PH_ID: begin
          result.byte_kind        = bbps_pkg::KIND_ID;
          result.block_number     = e_cb;
          length_accumulator_next = 32'd0;
          length_byte_index_next  = 2'd0;
          phase_next              = PH_LEN;
        end
        PH_LEN: begin
          result.byte_kind        = bbps_pkg::KIND_LEN;
          result.block_number     = e_cb;
          result.page_length      = acc_or;
          length_accumulator_next = acc_or;
          if (e_idx == 2'd3) begin
            length_byte_index_next = 2'd0;
            if (acc_or > rem_after) begin
              result.malformed = 1'b1;
              error_seen_next  = 1'b1;
              phase_next       = PH_DISCARD;
            end else if (acc_or == 32'd0) begin
              do_finish = 1'b1;
            end else begin
              page_bytes_left_next = acc_or;
              phase_next           = PH_PAGE;
            end
          end else begin
            length_byte_index_next = e_idx + 2'd1;
          end
        end
        PH_PAGE: begin
          result.byte_kind     = bbps_pkg::KIND_PAGE;
          result.block_number  = e_cb;
          result.page_length   = e_acc;
          page_bytes_left_next = pbl_dec;
          if (pbl_dec == 32'd0) begin
            do_finish = 1'b1;
          end
        end
        PH_MAIN: begin
          result.byte_kind = bbps_pkg::KIND_MAIN;
        end
        default: begin
          result.byte_kind = bbps_pkg::KIND_DISCARD;
        end
      endcase

      if (do_finish) begin
        blocks_remaining_next = br_dec;
        current_block_next    = e_cb + 8'd1;
        if (br_dec == 8'd0) begin
          phase_next = PH_MAIN;
        end else if (hdr_short) begin
          result.malformed = 1'b1;
          error_seen_next  = 1'b1;
          phase_next       = PH_DISCARD;
        end else begin
          phase_next = PH_ID;
        end
      end

      bytes_remaining_next = rem_after;
      if (rem_after == 32'd0) begin
        result.record_end = 1'b1;
        result.record_ok  = ~error_seen_next;
        phase_next        = PH_COUNT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_COUNT;
      bytes_remaining    <= 32'd0;
      blocks_remaining   <= 8'd0;
      current_block      <= 8'd0;
      length_accumulator <= 32'd0;
      length_byte_index  <= 2'd0;
      page_bytes_left    <= 32'd0;
      error_seen         <= 1'b0;
    end else if (advance) begin
      phase              <= phase_next;
      bytes_remaining    <= bytes_remaining_next;
      blocks_remaining   <= blocks_remaining_next;
      current_block      <= current_block_next;
      length_accumulator <= length_accumulator_next;
      length_byte_index  <= length_byte_index_next;
      page_bytes_left    <= page_bytes_left_next;
      error_seen         <= error_seen_next;
    end
  end

endmodule

/* rtl/core/backup_block_payload_splitter_core.sv */
// Top level of the backup block payload splitter: input register, parser, result register.
// Depends on bbps_pkg and bbps_parser.
//
// Takes one record payload byte per beat and returns one tagged beat per input beat,
// in order. Throughput is one byte per cycle while m_tready is high; a tagged beat passes
// through the input register, then the result register, before it is valid. The parse
// state updates as a beat moves from the input register to the result register, so
// the next byte is classified with the updated state. s_tready is low only while
// both registers are full and m_tready is low.
module backup_block_payload_splitter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // data_byte[7:0], payload_length[39:8]
  input  logic [1:0]  s_tuser,   // first_byte[0], images_present[1]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // byte_out[7:0], block_number[15:8], page_length[47:16]
  output logic [4:0]  m_tuser,   // byte_kind[2:0], malformed[3], record_ok[4]
  output logic        m_tlast    // record_end
);

  logic               in_valid;
  bbps_pkg::item_t    in_item;
  logic               out_valid;
  bbps_pkg::result_t  out_res;
  bbps_pkg::result_t  parse_res;
  logic               advance;

  assign advance  = in_valid & (~out_valid | m_tready);
  assign s_tready = ~in_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready & s_tvalid) begin
      in_item.data_byte      <= s_tdata[7:0];
      in_item.payload_length <= s_tdata[39:8];
      in_item.first_byte     <= s_tuser[0];
      in_item.images_present <= s_tuser[1];
    end
  end

  bbps_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_item),
    .result  (parse_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= parse_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_res.page_length, out_res.block_number, out_res.byte_out};
  assign m_tuser  = {out_res.record_ok, out_res.malformed, out_res.byte_kind};
  assign m_tlast  = out_res.record_end;

endmodule
